// ===== hdl/fpiq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpiq_pkg
// Shared types and constants for the front panel input qualifier.
// ----------------------------------------------------------------------------

package fpiq_pkg;

  // Configuration port geometry.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_COOLDOWN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KNOB_STEP = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GLITCH    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TEST_IDX  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_POPUP     = 3'd4;

  // Configuration reset values.
  localparam logic [15:0] COOLDOWN_RST  = 16'd200;
  localparam logic [5:0]  KNOB_STEP_RST = 6'd5;
  localparam logic [7:0]  GLITCH_RST    = 8'd20;
  localparam logic [2:0]  TEST_IDX_RST  = 3'd7;
  localparam logic [15:0] POPUP_RST     = 16'd3000;

  // Event codes.
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_UP     = 3'd1;
  localparam logic [2:0] EV_DOWN   = 3'd2;
  localparam logic [2:0] EV_TEST   = 3'd3;
  localparam logic [2:0] EV_PREV   = 3'd4;
  localparam logic [2:0] EV_NEXT   = 3'd5;
  localparam logic [2:0] EV_RESET  = 3'd6;
  localparam logic [2:0] EV_VOLUME = 3'd7;

  // Screen modes.
  localparam logic [1:0] MODE_HOME     = 2'd0;
  localparam logic [1:0] MODE_SETTINGS = 2'd1;
  localparam logic [1:0] MODE_RESET    = 2'd2;
  localparam logic [1:0] MODE_VOLUME   = 2'd3;

  // Knob scaling: (1023 - raw) / 5 as a multiply by 205 and a shift by 10,
  // exact for every 10-bit operand.
  localparam logic [9:0] KNOB_FULL  = 10'd1023;
  localparam logic [7:0] KNOB_RECIP = 8'd205;
  localparam int         KnobShift  = 10;

  // Volume snap points.
  localparam logic [9:0] SNAP_MID_HI = 10'd105;
  localparam logic [9:0] SNAP_MID_LO = 10'd95;
  localparam logic [9:0] SNAP_TOP_LO = 10'd195;
  localparam logic [9:0] SNAP_BOT_HI = 10'd5;
  localparam logic [7:0] VOL_MID     = 8'd100;
  localparam logic [7:0] VOL_MAX     = 8'd200;
  localparam logic [7:0] VOL_MIN     = 8'd0;

  // Configuration register set.
  typedef struct packed {
    logic [15:0] cooldown_ms;
    logic [5:0]  knob_step;
    logic [7:0]  glitch_window;
    logic [2:0]  test_menu_index;
    logic [15:0] popup_timeout_ms;
  } cfg_t;

  // Knob qualification result.
  typedef struct packed {
    logic       qualified;
    logic [7:0] level;
  } knob_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  event_code;
    logic [2:0]  menu_position;
    logic [1:0]  screen_mode;
    logic [7:0]  volume_level;
    logic [31:0] exit_deadline_ms;
  } result_t;

endpackage

// ===== hdl/fpiq_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpiq_cfg_regs
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------

module fpiq_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fpiq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fpiq_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output fpiq_pkg::cfg_t                 cfg_o
);

  fpiq_pkg::cfg_t cfg_q;

  // Register writes; indexes past the last register are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cooldown_ms      <= fpiq_pkg::COOLDOWN_RST;
      cfg_q.knob_step        <= fpiq_pkg::KNOB_STEP_RST;
      cfg_q.glitch_window    <= fpiq_pkg::GLITCH_RST;
      cfg_q.test_menu_index  <= fpiq_pkg::TEST_IDX_RST;
      cfg_q.popup_timeout_ms <= fpiq_pkg::POPUP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fpiq_pkg::CFG_COOLDOWN:  cfg_q.cooldown_ms      <= cfg_wdata_i;
        fpiq_pkg::CFG_KNOB_STEP: cfg_q.knob_step        <= cfg_wdata_i[5:0];
        fpiq_pkg::CFG_GLITCH:    cfg_q.glitch_window    <= cfg_wdata_i[7:0];
        fpiq_pkg::CFG_TEST_IDX:  cfg_q.test_menu_index  <= cfg_wdata_i[2:0];
        fpiq_pkg::CFG_POPUP:     cfg_q.popup_timeout_ms <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/fpiq_knob.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpiq_knob
// Scales the knob sample and checks it against step and glitch limits.
// ----------------------------------------------------------------------------

module fpiq_knob (
  input  logic [9:0]     knob_raw_i,
  input  logic [7:0]     last_volume_i,
  input  fpiq_pkg::cfg_t cfg_i,
  output fpiq_pkg::knob_t knob_o
);

  logic [9:0]  inv;
  logic [17:0] prod;
  logic [9:0]  level;
  logic [9:0]  last;
  logic [9:0]  step;
  logic [9:0]  gwin;
  logic        moved;
  logic        sane;
  logic [7:0]  snapped;

  // Reverse the knob and divide by five through the reciprocal.
  assign inv   = fpiq_pkg::KNOB_FULL - knob_raw_i;
  assign prod  = 18'(inv) * 18'(fpiq_pkg::KNOB_RECIP);
  assign level = {2'b00, prod[fpiq_pkg::KnobShift +: 8]};

  assign last = {2'b00, last_volume_i};
  assign step = {4'b0000, cfg_i.knob_step};
  assign gwin = {2'b00, cfg_i.glitch_window};

  // The change must reach the step but stay inside the glitch window.
  assign moved = (level >= last + step) || (level + step <= last);
  assign sane  = (level < last + gwin) && (level + gwin > last);

  // Snap near the middle and both ends of the range.
  always_comb begin
    if (level <= fpiq_pkg::SNAP_MID_HI && level >= fpiq_pkg::SNAP_MID_LO) begin
      snapped = fpiq_pkg::VOL_MID;
    end else if (level > fpiq_pkg::SNAP_TOP_LO) begin
      snapped = fpiq_pkg::VOL_MAX;
    end else if (level < fpiq_pkg::SNAP_BOT_HI) begin
      snapped = fpiq_pkg::VOL_MIN;
    end else begin
      snapped = level[7:0];
    end
  end

  assign knob_o.qualified = moved && sane;
  assign knob_o.level     = snapped;

endmodule

// ===== hdl/fpiq_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpiq_core
// Button priority, cooldown checks and panel state for one poll.
// ----------------------------------------------------------------------------

module fpiq_core #(
  parameter int MENU_COUNT = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [31:0]      now_ms_i,
  input  logic             press_up_i,
  input  logic             press_down_i,
  input  logic             press_left_i,
  input  logic             press_right_i,
  input  logic             press_clear_i,
  input  logic [9:0]       knob_raw_i,
  input  fpiq_pkg::cfg_t   cfg_i,
  output fpiq_pkg::result_t res_o
);

  localparam int IdxW = (MENU_COUNT > 1) ? $clog2(MENU_COUNT) : 1;

  // A stamp is due when stamp + interval <= now, with no wrap of the sum.
  function automatic logic due(input logic [31:0] stamp, input logic [16:0] interval,
                               input logic [31:0] now);
    return ({1'b0, stamp} + 33'(interval)) <= {1'b0, now};
  endfunction

  logic [31:0]     up_time_q, up_time_d;
  logic [31:0]     down_time_q, down_time_d;
  logic [31:0]     left_time_q, left_time_d;
  logic [31:0]     right_time_q, right_time_d;
  logic [31:0]     clear_time_q, clear_time_d;
  logic [31:0]     any_time_q, any_time_d;
  logic [7:0]      volume_q, volume_d;
  logic [IdxW-1:0] menu_q, menu_d;
  logic [1:0]      mode_q, mode_d;
  logic [31:0]     deadline_q, deadline_d;
  logic [2:0]      event_code;

  logic [16:0]     cd;
  logic [16:0]     cd2;
  logic            take_up, take_down, take_left, take_right, take_clear;
  logic            on_test;
  logic            menu_last;
  logic [IdxW+2:0] menu_ext;
  logic [31:0]     deadline_new;
  fpiq_pkg::knob_t knob;

  fpiq_knob u_knob (
    .knob_raw_i    (knob_raw_i),
    .last_volume_i (volume_q),
    .cfg_i         (cfg_i),
    .knob_o        (knob)
  );

  assign cd  = {1'b0, cfg_i.cooldown_ms};
  assign cd2 = {cfg_i.cooldown_ms, 1'b0};

  // Each held button whose own cooldown has passed.
  assign take_up    = press_up_i    && due(up_time_q, cd, now_ms_i);
  assign take_down  = press_down_i  && due(down_time_q, cd, now_ms_i);
  assign take_left  = press_left_i  && due(left_time_q, cd, now_ms_i);
  assign take_right = press_right_i && due(right_time_q, cd, now_ms_i);
  assign take_clear = press_clear_i && due(clear_time_q, cd, now_ms_i);

  assign on_test   = {3'b000, menu_q} == {{IdxW{1'b0}}, cfg_i.test_menu_index};
  assign menu_last = ({1'b0, menu_q} + (IdxW+1)'(1)) >= (IdxW+1)'(MENU_COUNT);
  assign deadline_new = now_ms_i + {16'h0000, cfg_i.popup_timeout_ms};

  // Priority decision: up, down, left, right, reset, then the knob.
  always_comb begin
    up_time_d    = up_time_q;
    down_time_d  = down_time_q;
    left_time_d  = left_time_q;
    right_time_d = right_time_q;
    clear_time_d = clear_time_q;
    any_time_d   = any_time_q;
    volume_d     = volume_q;
    menu_d       = menu_q;
    mode_d       = mode_q;
    deadline_d   = deadline_q;
    event_code   = fpiq_pkg::EV_NONE;
    if (take_up) begin
      if (mode_q == fpiq_pkg::MODE_SETTINGS) begin
        up_time_d  = now_ms_i;
        any_time_d = now_ms_i;
        event_code = on_test ? fpiq_pkg::EV_TEST : fpiq_pkg::EV_UP;
      end
    end else if (take_down) begin
      if (mode_q == fpiq_pkg::MODE_SETTINGS) begin
        down_time_d = now_ms_i;
        any_time_d  = now_ms_i;
        event_code  = on_test ? fpiq_pkg::EV_TEST : fpiq_pkg::EV_DOWN;
      end
    end else if (take_left) begin
      left_time_d = now_ms_i;
      any_time_d  = now_ms_i;
      menu_d      = (menu_q == '0) ? IdxW'(MENU_COUNT - 1) : menu_q - IdxW'(1);
      mode_d      = fpiq_pkg::MODE_SETTINGS;
      event_code  = fpiq_pkg::EV_PREV;
    end else if (take_right) begin
      right_time_d = now_ms_i;
      any_time_d   = now_ms_i;
      menu_d       = menu_last ? '0 : menu_q + IdxW'(1);
      mode_d       = fpiq_pkg::MODE_SETTINGS;
      event_code   = fpiq_pkg::EV_NEXT;
    end else if (take_clear) begin
      clear_time_d = now_ms_i;
      deadline_d   = deadline_new;
      mode_d       = fpiq_pkg::MODE_RESET;
      event_code   = fpiq_pkg::EV_RESET;
    end else if (knob.qualified && due(any_time_q, cd2, now_ms_i)) begin
      volume_d   = knob.level;
      deadline_d = deadline_new;
      mode_d     = fpiq_pkg::MODE_VOLUME;
      event_code = fpiq_pkg::EV_VOLUME;
    end
  end

  // Panel state advances once per transfer into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_time_q    <= '0;
      down_time_q  <= '0;
      left_time_q  <= '0;
      right_time_q <= '0;
      clear_time_q <= '0;
      any_time_q   <= '0;
      volume_q     <= '0;
      menu_q       <= '0;
      mode_q       <= fpiq_pkg::MODE_HOME;
      deadline_q   <= '0;
    end else if (fire_i) begin
      up_time_q    <= up_time_d;
      down_time_q  <= down_time_d;
      left_time_q  <= left_time_d;
      right_time_q <= right_time_d;
      clear_time_q <= clear_time_d;
      any_time_q   <= any_time_d;
      volume_q     <= volume_d;
      menu_q       <= menu_d;
      mode_q       <= mode_d;
      deadline_q   <= deadline_d;
    end
  end

  // Result shows the state after this poll; the menu index is cut to three bits.
  assign menu_ext = {3'b000, menu_d};

  assign res_o.event_code       = event_code;
  assign res_o.menu_position    = menu_ext[2:0];
  assign res_o.screen_mode      = mode_d;
  assign res_o.volume_level     = volume_d;
  assign res_o.exit_deadline_ms = deadline_d;

endmodule

// ===== hdl/front_panel_input_qualifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// front_panel_input_qualifier
// Qualifies front panel button and knob polls into panel events.
// ----------------------------------------------------------------------------
// Throughput: one poll per cycle while the result channel is not stalled; the
// input register and result register each hold one item, and the panel state
// is updated as an item enters the result register. Reset clears all panel
// state and loads the default configuration; no clearing pass is needed.

module front_panel_input_qualifier #(
  parameter int MENU_COUNT = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [fpiq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fpiq_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Poll channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [31:0]                   now_ms_i,
  input  logic                          press_up_i,
  input  logic                          press_down_i,
  input  logic                          press_left_i,
  input  logic                          press_right_i,
  input  logic                          press_clear_i,
  input  logic [9:0]                    knob_raw_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    event_code_o,
  output logic [2:0]                    menu_position_o,
  output logic [1:0]                    screen_mode_o,
  output logic [7:0]                    volume_level_o,
  output logic [31:0]                   exit_deadline_ms_o
);

  fpiq_pkg::cfg_t    cfg;
  fpiq_pkg::result_t res;
  fpiq_pkg::result_t res_q;

  logic        in_valid_q;
  logic [31:0] now_q;
  logic [4:0]  press_q;
  logic [9:0]  knob_q;
  logic        out_valid_q;
  logic        out_free;
  logic        fire;
  logic        in_xfer;

  fpiq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Pipeline handshake: the result register frees itself when taken.
  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      now_q   <= now_ms_i;
      press_q <= {press_up_i, press_down_i, press_left_i, press_right_i, press_clear_i};
      knob_q  <= knob_raw_i;
    end
  end

  fpiq_core #(
    .MENU_COUNT (MENU_COUNT)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .now_ms_i      (now_q),
    .press_up_i    (press_q[4]),
    .press_down_i  (press_q[3]),
    .press_left_i  (press_q[2]),
    .press_right_i (press_q[1]),
    .press_clear_i (press_q[0]),
    .knob_raw_i    (knob_q),
    .cfg_i         (cfg),
    .res_o         (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign event_code_o       = res_q.event_code;
  assign menu_position_o    = res_q.menu_position;
  assign screen_mode_o      = res_q.screen_mode;
  assign volume_level_o     = res_q.volume_level;
  assign exit_deadline_ms_o = res_q.exit_deadline_ms;

  // A volume event always shows the volume screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_code_o == fpiq_pkg::EV_VOLUME)
      |-> (screen_mode_o == fpiq_pkg::MODE_VOLUME))
    else $error("volume event without volume screen");

  // Menu steps always land in settings mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_code_o == fpiq_pkg::EV_PREV || event_code_o == fpiq_pkg::EV_NEXT))
      |-> (screen_mode_o == fpiq_pkg::MODE_SETTINGS))
    else $error("menu step outside settings mode");

  // A reset event always shows the reset screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_code_o == fpiq_pkg::EV_RESET)
      |-> (screen_mode_o == fpiq_pkg::MODE_RESET))
    else $error("reset event without reset screen");

  // Snapped volume never exceeds full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (volume_level_o <= fpiq_pkg::VOL_MAX))
    else $error("volume above full scale");

  // A stalled result register with a held item must block new polls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("poll accepted while pipeline is full");

endmodule
